// ===== sv/gwnt_pkg.sv =====
// Shared types and constants of the grid wall-neighbour tile store.
package gwnt_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 64;
   localparam int DEFAULT_MAX_HEIGHT = 64;

   localparam int COORD_W = 6;
   localparam int SIZE_W  = 7;
   localparam int CHAR_W  = 8;
   localparam int TILE_W  = 5;

   typedef logic [1:0] cell_class_type;

   localparam cell_class_type CLS_EMPTY = 2'd0;
   localparam cell_class_type CLS_WALL  = 2'd1;
   localparam cell_class_type CLS_DOWN  = 2'd2;
   localparam cell_class_type CLS_UP    = 2'd3;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_GRID_WIDTH  = 1'd0;
   localparam csr_index_type CSR_GRID_HEIGHT = 1'd1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_DOWN  = 8'h3E;
   localparam logic [CHAR_W-1:0] CHAR_UP    = 8'h3C;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [TILE_W-1:0] TILE_EMPTY = 5'd0;
   localparam logic [TILE_W-1:0] TILE_DOWN  = 5'd17;
   localparam logic [TILE_W-1:0] TILE_UP    = 5'd18;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

endpackage

// ===== sv/gwnt_cell_ram.sv =====
// Single-port cell class memory with registered read data.
module gwnt_cell_ram
   import gwnt_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_MAX_WIDTH * DEFAULT_MAX_HEIGHT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  cell_class_type    wdata,
   output cell_class_type    rdata
);

   cell_class_type mem [DEPTH];
   cell_class_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/gwnt_seq.sv =====
// Sequencer: clearing sweep, cell writes and five-read neighbour query.
module gwnt_seq
   import gwnt_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
   parameter int ADDR_W     = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SIZE_W-1:0]  grid_width,
   input  logic [SIZE_W-1:0]  grid_height,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row,
   input  logic [CHAR_W-1:0]  req_map_char,
   output logic               rsp_valid,
   output logic [TILE_W-1:0]  rsp_tile_code,
   output logic               rsp_is_wall,
   output logic               rsp_is_moveable,
   output logic               ram_we,
   output logic [ADDR_W-1:0]  ram_addr,
   output cell_class_type     ram_wdata,
   input  cell_class_type     ram_rdata
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_QUERY = 2'd3;

   localparam logic [2:0] STEP_CENTER = 3'd0;
   localparam logic [2:0] STEP_NORTH  = 3'd1;
   localparam logic [2:0] STEP_EAST   = 3'd2;
   localparam logic [2:0] STEP_SOUTH  = 3'd3;
   localparam logic [2:0] STEP_WEST   = 3'd4;
   localparam logic [2:0] STEP_LAST   = 3'd5;

   localparam int PT_W = 8;
   localparam int PROD_W = PT_W + 10;
   localparam logic [8:0] MAX_W9 = 9'(MAX_WIDTH);
   localparam logic [8:0] MAX_H9 = 9'(MAX_HEIGHT);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [1:0]          state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [COORD_W-1:0]  col_ff, col_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                prev_ok_ff, prev_ok_in;
   logic                center_ok_ff, center_ok_in;
   cell_class_type      center_ff, center_in;
   logic [3:0]          mask_ff, mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TILE_W-1:0]   code_ff, code_in;
   logic                wall_ff, wall_in;
   logic                move_ff, move_in;

   logic [SIZE_W-1:0]   eff_w, eff_h;
   logic [PT_W-1:0]     pt_col, pt_row;
   logic                pt_ok;
   logic [PROD_W-1:0]   pt_addr_wide;
   logic [ADDR_W-1:0]   center_addr, pt_addr;
   cell_class_type      wr_class;
   logic [3:0]          mask_final;
   logic [1:0]          mask_sel;

   // Saturate the size registers to the built grid.
   always_comb begin
      eff_w = grid_width;
      eff_h = grid_height;
      if ({2'b00, grid_width} > MAX_W9) begin
         eff_w = MAX_W9[SIZE_W-1:0];
      end
      if ({2'b00, grid_height} > MAX_H9) begin
         eff_h = MAX_H9[SIZE_W-1:0];
      end
   end

   // Shared coordinate unit: pick the cell of this step, check range, form address.
   always_comb begin
      pt_col = PT_W'(col_ff);
      pt_row = PT_W'(row_ff);
      case (step_ff)
         STEP_NORTH: pt_row = PT_W'(row_ff) - 8'd1;
         STEP_EAST:  pt_col = PT_W'(col_ff) + 8'd1;
         STEP_SOUTH: pt_row = PT_W'(row_ff) + 8'd1;
         STEP_WEST:  pt_col = PT_W'(col_ff) - 8'd1;
         default:    ;
      endcase
      pt_ok = (pt_col < PT_W'(eff_w)) && (pt_row < PT_W'(eff_h));
      pt_addr_wide = PROD_W'(pt_row) * PROD_W'(MAX_WIDTH) + PROD_W'(pt_col);
      center_addr = ADDR_W'(PROD_W'(row_ff) * PROD_W'(MAX_WIDTH) + PROD_W'(col_ff));
      pt_addr = pt_ok ? pt_addr_wide[ADDR_W-1:0] : center_addr;
   end

   always_comb begin
      if (char_ff == CHAR_DOWN) begin
         wr_class = CLS_DOWN;
      end else if (char_ff == CHAR_UP) begin
         wr_class = CLS_UP;
      end else if (char_ff != CHAR_SPACE) begin
         wr_class = CLS_WALL;
      end else begin
         wr_class = CLS_EMPTY;
      end
   end

   assign mask_final = mask_ff |
      {(prev_ok_ff && ram_rdata == CLS_WALL), 3'b000};

   // Data arriving at the east step belongs to north, so bit 0.
   assign mask_sel = 2'(step_ff - STEP_EAST);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      char_in      = char_ff;
      prev_ok_in   = prev_ok_ff;
      center_ok_in = center_ok_ff;
      center_in    = center_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      code_in      = code_ff;
      wall_in      = wall_ff;
      move_in      = move_ff;
      ram_we       = 1'b0;
      ram_addr     = pt_addr;
      ram_wdata    = wr_class;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = CLS_EMPTY;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               col_in   = req_col;
               row_in   = req_row;
               char_in  = req_map_char;
               step_in  = STEP_CENTER;
               mask_in  = 4'd0;
               state_in = (req_func == FUNC_WRITE) ? ST_WRITE : ST_QUERY;
            end
         end
         ST_WRITE: begin
            // Step is at the center here; drop writes outside the grid.
            ram_we   = pt_ok;
            state_in = ST_IDLE;
         end
         default: begin
            // Issue read for this step; consume the data of the previous one.
            prev_ok_in = pt_ok;
            step_in    = step_ff + 3'd1;
            if (step_ff == STEP_NORTH) begin
               center_in    = ram_rdata;
               center_ok_in = prev_ok_ff;
            end else if (step_ff != STEP_CENTER && step_ff != STEP_LAST) begin
               mask_in[mask_sel] = prev_ok_ff && ram_rdata == CLS_WALL;
            end
            if (step_ff == STEP_LAST) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               code_in      = TILE_EMPTY;
               wall_in      = 1'b0;
               move_in      = 1'b0;
               if (center_ok_ff) begin
                  if (center_ff == CLS_WALL) begin
                     code_in = TILE_W'(mask_final) + 5'd1;
                     wall_in = 1'b1;
                  end else begin
                     move_in = 1'b1;
                     if (center_ff == CLS_DOWN) begin
                        code_in = TILE_DOWN;
                     end else if (center_ff == CLS_UP) begin
                        code_in = TILE_UP;
                     end
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= STEP_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      char_ff      <= char_in;
      prev_ok_ff   <= prev_ok_in;
      center_ok_ff <= center_ok_in;
      center_ff    <= center_in;
      mask_ff      <= mask_in;
      code_ff      <= code_in;
      wall_ff      <= wall_in;
      move_ff      <= move_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_code   = code_ff;
   assign rsp_is_wall     = wall_ff;
   assign rsp_is_moveable = move_ff;

endmodule

// ===== sv/grid_wall_neighbour_tile_store_unit.sv =====
// Top level of the grid wall-neighbour tile store: size registers, sequencer, cell memory.
// Write beat: busy for 1 cycle after acceptance; no result.
// Query beat: busy through the query steps; one memory port reads the center and four
// neighbours, one a cycle, and the result strobes on rsp_valid for one cycle as busy drops.
// Reset: size registers go to 64; then a clearing pass writes empty to all
// MAX_WIDTH*MAX_HEIGHT cells, one per cycle, with busy high. Config writes are always taken.
module grid_wall_neighbour_tile_store_unit
   import gwnt_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row,
   input  logic [CHAR_W-1:0]  req_map_char,
   // result strobe; the receiver cannot hold it off
   output logic               rsp_valid,
   output logic [TILE_W-1:0]  rsp_tile_code,
   output logic               rsp_is_wall,
   output logic               rsp_is_moveable,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  csr_index_type      csr_index,
   input  logic [SIZE_W-1:0]  csr_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [SIZE_W-1:0] grid_width_ff, grid_width_in;
   logic [SIZE_W-1:0] grid_height_ff, grid_height_in;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   cell_class_type    ram_wdata;
   cell_class_type    ram_rdata;

   // Registers must be written only while idle; the block does not enforce it, so always accept the beat.
   assign csr_ready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_data;
            CSR_GRID_HEIGHT: grid_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_RESET;
         grid_height_ff <= SIZE_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // Sequencer owns the single memory port: clearing sweep, writes, and the five query reads.
   gwnt_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH      (DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .grid_width      (grid_width_ff),
      .grid_height     (grid_height_ff),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_map_char    (req_map_char),
      .rsp_valid       (rsp_valid),
      .rsp_tile_code   (rsp_tile_code),
      .rsp_is_wall     (rsp_is_wall),
      .rsp_is_moveable (rsp_is_moveable),
      .ram_we          (ram_we),
      .ram_addr        (ram_addr),
      .ram_wdata       (ram_wdata),
      .ram_rdata       (ram_rdata)
   );

   // Cell class store, addressed row*MAX_WIDTH+col.
   gwnt_cell_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

// ===== tb/grid_wall_neighbour_tile_store_unit_tb.sv =====
// Self-checking testbench for the grid wall-neighbour tile store: directed table, then random phases.
module grid_wall_neighbour_tile_store_unit_tb;
   import gwnt_pkg::*;

   localparam int GRID_COLS       = DEFAULT_MAX_WIDTH;
   localparam int GRID_ROWS       = DEFAULT_MAX_HEIGHT;
   localparam int RESET_CYCLES    = 8;
   // a write keeps the block busy one cycle and gives no result; let it finish
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 20;
   // covers the clearing pass after reset with plenty of room
   localparam int STALL_LIMIT     = 4 * GRID_COLS * GRID_ROWS + 2000;
   localparam int RANDOM_PHASES   = 12;
   localparam int FIXED_PHASES    = 8;
   localparam int BEATS_PER_PHASE = 150;
   localparam int WINDOW_SPAN     = 8;
   localparam int WINDOW_REFRESH  = 32;

   localparam logic [TILE_W-1:0] TILE_WALL_BASE = 5'd1;
   localparam logic [TILE_W-1:0] MASK_NORTH     = 5'd1;
   localparam logic [TILE_W-1:0] MASK_EAST      = 5'd2;
   localparam logic [TILE_W-1:0] MASK_SOUTH     = 5'd4;
   localparam logic [TILE_W-1:0] MASK_WEST      = 5'd8;
   localparam logic [CHAR_W-1:0] WALL_GLYPH     = 8'h23;

   typedef struct packed {
      logic [TILE_W-1:0] tile_code;
      logic              is_wall;
      logic              is_moveable;
   } tile_rsp_type;

   typedef struct {
      tile_rsp_type rsp;
      int           col;
      int           row;
   } tile_expect_type;

   typedef enum {STEP_BEAT, STEP_SIZE} step_kind_type;

   typedef struct {
      step_kind_type     kind;
      logic              func;
      int                col;
      int                row;
      logic [CHAR_W-1:0] map_char;
      csr_index_type     csr_sel;
      logic [SIZE_W-1:0] csr_val;
      bit                typed;
      tile_rsp_type      rsp;
   } stim_step_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               req_func        = FUNC_WRITE;
   logic [COORD_W-1:0] req_col         = '0;
   logic [COORD_W-1:0] req_row         = '0;
   logic [CHAR_W-1:0]  req_map_char    = '0;
   logic               csr_valid       = 1'b0;
   csr_index_type      csr_index       = CSR_GRID_WIDTH;
   logic [SIZE_W-1:0]  csr_data        = '0;
   logic               busy;
   logic               rsp_valid;
   logic [TILE_W-1:0]  rsp_tile_code;
   logic               rsp_is_wall;
   logic               rsp_is_moveable;
   logic               csr_ready;

   // shadow copy of the cell store and of the effective (saturated) grid size
   cell_class_type cell_map [GRID_COLS*GRID_ROWS];
   int             cols_live = GRID_COLS;
   int             rows_live = GRID_ROWS;

   tile_expect_type pending_tiles [$];
   stim_step_type   directed_plan [$];
   int              fail_count   = 0;
   int              stall_cycles = 0;
   bit              no_gaps      = 1'b0;

   always #6 clock = ~clock;

   grid_wall_neighbour_tile_store_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_map_char    (req_map_char),
      .rsp_valid       (rsp_valid),
      .rsp_tile_code   (rsp_tile_code),
      .rsp_is_wall     (rsp_is_wall),
      .rsp_is_moveable (rsp_is_moveable),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // Cells off the live grid never count as wall neighbours; coordinates are
   // plain ints so that col 63 + 1 does not wrap back to column 0.
   function automatic bit wall_at_cell(int c, int r);
      if (c < 0 || r < 0 || c >= cols_live || r >= rows_live) return 1'b0;
      return cell_map[r*GRID_COLS + c] == CLS_WALL;
   endfunction

   // Apply one beat to the shadow store; return 1 when it yields a tile result.
   function automatic bit step_tile_store(logic func, int c, int r, logic [CHAR_W-1:0] ch,
                                          output tile_rsp_type rsp);
      cell_class_type cls;
      bit             on_grid;
      on_grid = c < cols_live && r < rows_live;
      rsp     = '0;
      if (func == FUNC_WRITE) begin
         if (on_grid) begin
            if (ch == CHAR_DOWN)       cls = CLS_DOWN;
            else if (ch == CHAR_UP)    cls = CLS_UP;
            else if (ch == CHAR_SPACE) cls = CLS_EMPTY;
            else                       cls = CLS_WALL;
            cell_map[r*GRID_COLS + c] = cls;
         end
         return 1'b0;
      end
      if (on_grid) begin
         cls = cell_map[r*GRID_COLS + c];
         if (cls == CLS_WALL) begin
            rsp.tile_code = TILE_WALL_BASE;
            if (wall_at_cell(c, r - 1)) rsp.tile_code += MASK_NORTH;
            if (wall_at_cell(c + 1, r)) rsp.tile_code += MASK_EAST;
            if (wall_at_cell(c, r + 1)) rsp.tile_code += MASK_SOUTH;
            if (wall_at_cell(c - 1, r)) rsp.tile_code += MASK_WEST;
            rsp.is_wall = 1'b1;
         end else begin
            rsp.is_moveable = 1'b1;
            if (cls == CLS_DOWN)     rsp.tile_code = TILE_DOWN;
            else if (cls == CLS_UP)  rsp.tile_code = TILE_UP;
            else                     rsp.tile_code = TILE_EMPTY;
         end
      end
      return 1'b1;
   endfunction

   function automatic void plan_beat(logic func, int c, int r, logic [CHAR_W-1:0] ch,
                                     bit typed = 1'b0, logic [TILE_W-1:0] tile = '0,
                                     bit wall = 1'b0, bit move = 1'b0);
      stim_step_type s;
      s.kind            = STEP_BEAT;
      s.func            = func;
      s.col             = c;
      s.row             = r;
      s.map_char        = ch;
      s.csr_sel         = CSR_GRID_WIDTH;
      s.csr_val         = '0;
      s.typed           = typed;
      s.rsp.tile_code   = tile;
      s.rsp.is_wall     = wall;
      s.rsp.is_moveable = move;
      directed_plan.push_back(s);
   endfunction

   function automatic void plan_size(csr_index_type sel, logic [SIZE_W-1:0] val);
      stim_step_type s;
      s.kind     = STEP_SIZE;
      s.func     = FUNC_WRITE;
      s.col      = 0;
      s.row      = 0;
      s.map_char = '0;
      s.csr_sel  = sel;
      s.csr_val  = val;
      s.typed    = 1'b0;
      s.rsp      = '0;
      directed_plan.push_back(s);
   endfunction

   // Drive one command beat, hold it until the block takes it, then predict.
   // start is lowered only when a gap follows, so it never toggles within a step.
   task automatic send_beat(logic func, int c, int r, logic [CHAR_W-1:0] ch,
                            bit typed, tile_rsp_type typed_rsp);
      int              gap;
      int              pick;
      tile_rsp_type    rsp;
      tile_expect_type entry;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 60) gap = 0;
      else if (pick < 92)       gap = $urandom_range(1, 3);
      else                      gap = $urandom_range(10, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_func     <= func;
      req_col      <= c[COORD_W-1:0];
      req_row      <= r[COORD_W-1:0];
      req_map_char <= ch;
      do @(posedge clock); while (busy !== 1'b0);
      if (step_tile_store(func, c, r, ch, rsp)) begin
         entry.rsp = typed ? typed_rsp : rsp;
         entry.col = c;
         entry.row = r;
         pending_tiles.push_back(entry);
      end
   endtask

   // Write a size register once the block has gone quiet.
   task automatic write_size(csr_index_type sel, logic [SIZE_W-1:0] val);
      // drop start first so the last beat is not taken a second time
      start <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (sel == CSR_GRID_WIDTH) cols_live = (val > GRID_COLS) ? GRID_COLS : int'(val);
      else                       rows_live = (val > GRID_ROWS) ? GRID_ROWS : int'(val);
   endtask

   // Compare every strobed result against the oldest expectation.
   always @(posedge clock) begin
      tile_expect_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_tiles.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual code %0d wall %0b move %0b",
                     $time, rsp_tile_code, rsp_is_wall, rsp_is_moveable);
         end else begin
            want = pending_tiles.pop_front();
            if (rsp_tile_code !== want.rsp.tile_code || rsp_is_wall !== want.rsp.is_wall ||
                rsp_is_moveable !== want.rsp.is_moveable) begin
               fail_count++;
               $display("%0t: mismatch (%0d,%0d) expected %0d %0b %0b, actual %0d %0b %0b",
                        $time, want.col, want.row, want.rsp.tile_code, want.rsp.is_wall,
                        want.rsp.is_moveable, rsp_tile_code, rsp_is_wall, rsp_is_moveable);
            end
         end
      end
   end

   // Abort when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || (csr_valid === 1'b1 && csr_ready === 1'b1) ||
          rsp_valid === 1'b1)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int                fixed_cols [FIXED_PHASES];
      int                fixed_rows [FIXED_PHASES];
      int                w;
      int                h;
      int                ox;
      int                oy;
      int                c;
      int                r;
      int                pick;
      logic              func;
      logic [CHAR_W-1:0] ch;
      tile_rsp_type      none;

      // extremes: width zero, one, parameter, just past it, all ones; height one, parameter, all ones
      fixed_cols = '{1, 2, 5, 64, 0, 127, 3, 65};
      fixed_rows = '{1, 3, 4, 64, 5, 127, 64, 2};
      none       = '0;
      foreach (cell_map[i]) cell_map[i] = CLS_EMPTY;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Rows with a typed result are obvious from the rules;
      // the rest are left to the predictor.
      plan_beat(FUNC_QUERY, 0, 0, 8'h00, 1'b1, TILE_EMPTY, 1'b0, 1'b1);   // cleared at reset
      plan_beat(FUNC_QUERY, 63, 63, 8'hFF, 1'b1, TILE_EMPTY, 1'b0, 1'b1);
      plan_beat(FUNC_WRITE, 0, 0, WALL_GLYPH);
      plan_beat(FUNC_QUERY, 0, 0, CHAR_DOWN, 1'b1, TILE_WALL_BASE, 1'b1, 1'b0); // lone wall
      plan_beat(FUNC_WRITE, 1, 0, 8'hFF);
      plan_beat(FUNC_WRITE, 0, 1, 8'h00);
      plan_beat(FUNC_QUERY, 0, 0, CHAR_SPACE);                             // east and south
      plan_beat(FUNC_WRITE, 63, 63, CHAR_DOWN);
      plan_beat(FUNC_QUERY, 63, 63, 8'h00, 1'b1, TILE_DOWN, 1'b0, 1'b1);
      plan_beat(FUNC_WRITE, 63, 62, CHAR_UP);
      plan_beat(FUNC_QUERY, 63, 62, 8'h00, 1'b1, TILE_UP, 1'b0, 1'b1);
      plan_beat(FUNC_WRITE, 1, 0, CHAR_SPACE);                             // wall back to empty
      plan_beat(FUNC_QUERY, 0, 0, 8'h00);
      // ring of walls around (62,62), east one on the last column
      plan_beat(FUNC_WRITE, 62, 62, 8'h78);
      plan_beat(FUNC_WRITE, 61, 62, 8'h80);
      plan_beat(FUNC_WRITE, 62, 61, 8'h7F);
      plan_beat(FUNC_WRITE, 62, 63, 8'h01);
      plan_beat(FUNC_WRITE, 63, 62, 8'h3D);
      plan_beat(FUNC_QUERY, 62, 62, 8'h00);                                // all four neighbours
      plan_beat(FUNC_QUERY, 63, 62, 8'h00);                                // east edge of the grid
      // shrink: the bottom row drops out of view but keeps its contents
      plan_size(CSR_GRID_HEIGHT, 7'd63);
      plan_beat(FUNC_QUERY, 62, 62, 8'h00);
      plan_beat(FUNC_QUERY, 62, 63, 8'h00, 1'b1, TILE_EMPTY, 1'b0, 1'b0); // out of range
      plan_beat(FUNC_WRITE, 0, 63, WALL_GLYPH);                            // dropped
      plan_size(CSR_GRID_HEIGHT, 7'd127);                                  // saturates to 64
      plan_beat(FUNC_QUERY, 0, 63, 8'h00, 1'b1, TILE_EMPTY, 1'b0, 1'b1);
      plan_beat(FUNC_QUERY, 62, 62, 8'h00);
      plan_size(CSR_GRID_WIDTH, 7'd0);                                     // nothing in range
      plan_beat(FUNC_QUERY, 0, 0, 8'h00, 1'b1, TILE_EMPTY, 1'b0, 1'b0);
      plan_size(CSR_GRID_WIDTH, SIZE_RESET);
      plan_beat(FUNC_QUERY, 0, 1, 8'h00);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_SIZE)
            write_size(directed_plan[i].csr_sel, directed_plan[i].csr_val);
         else
            send_beat(directed_plan[i].func, directed_plan[i].col, directed_plan[i].row,
                      directed_plan[i].map_char, directed_plan[i].typed, directed_plan[i].rsp);
      end

      // Random phases: each picks a grid size, then hammers a small window that
      // roams over the grid so walls cluster and neighbour masks fill in.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < FIXED_PHASES) begin
            w = fixed_cols[p];
            h = fixed_rows[p];
         end else begin
            w = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 10) : $urandom_range(0, 127);
            h = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 10) : $urandom_range(0, 127);
         end
         if ($urandom_range(0, 1) == 0) begin
            write_size(CSR_GRID_WIDTH, w[SIZE_W-1:0]);
            write_size(CSR_GRID_HEIGHT, h[SIZE_W-1:0]);
         end else begin
            write_size(CSR_GRID_HEIGHT, h[SIZE_W-1:0]);
            write_size(CSR_GRID_WIDTH, w[SIZE_W-1:0]);
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // move the window now and then; it may hang past the far edge
            if (n % WINDOW_REFRESH == 0) begin
               ox = (cols_live <= WINDOW_SPAN - 2) ? 0 :
                    $urandom_range(0, cols_live - (WINDOW_SPAN - 2));
               oy = (rows_live <= WINDOW_SPAN - 2) ? 0 :
                    $urandom_range(0, rows_live - (WINDOW_SPAN - 2));
            end
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, GRID_COLS - 1) :
                ox + $urandom_range(0, WINDOW_SPAN - 1);
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, GRID_ROWS - 1) :
                oy + $urandom_range(0, WINDOW_SPAN - 1);
            if (c > GRID_COLS - 1) c = GRID_COLS - 1;
            if (r > GRID_ROWS - 1) r = GRID_ROWS - 1;
            func = ($urandom_range(0, 99) < 45) ? FUNC_QUERY : FUNC_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               ch = CHAR_W'($urandom_range(33, 126));
               if (ch == CHAR_DOWN || ch == CHAR_UP) ch = WALL_GLYPH;
            end else if (pick < 50) ch = CHAR_DOWN;
            else if (pick < 60)     ch = CHAR_UP;
            else if (pick < 85)     ch = CHAR_SPACE;
            else                    ch = CHAR_W'($urandom_range(0, 255));
            send_beat(func, c, r, ch, 1'b0, none);
         end
      end

      // Drain: drop start, wait for the last results, then watch for strays.
      start <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
